FILE: rtl/core/rlcg_pkg.sv
// Shared types and constants of the raster laser command generator.
// Used by rlcg_front, rlcg_queue, rlcg_back and the top level; no dependencies.
package rlcg_pkg;

	localparam int COORD_W     = 13;
	localparam int LEVEL_W     = 8;
	localparam int DWELL_W     = 16;
	localparam int SIZE_REG_W  = 13;
	localparam int GAIN_W      = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int STEP_COUNT  = 14;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [LEVEL_W-1:0] PIXEL_MAX = 8'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_POWER_GAIN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_ENABLE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_ENABLE  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TIME    = 3'd5;

	typedef enum logic [2:0] {
		CMD_SET_POWER   = 3'd0,
		CMD_HOME        = 3'd1,
		CMD_WAIT_MOTION = 3'd2,
		CMD_LASER_ON    = 3'd3,
		CMD_LASER_OFF   = 3'd4,
		CMD_MOVE        = 3'd5,
		CMD_DWELL       = 3'd6
	} cmd_t;

	// One bit per possible command of a pixel, in emission order.
	typedef enum logic [3:0] {
		STEP_START_OFF  = 4'd0,
		STEP_START_HOME = 4'd1,
		STEP_START_WAIT = 4'd2,
		STEP_LASER_ON   = 4'd3,
		STEP_ROW_MOVE   = 4'd4,
		STEP_X_MOVE     = 4'd5,
		STEP_SET_POWER  = 4'd6,
		STEP_DWELL      = 4'd7,
		STEP_RUN_OFF    = 4'd8,
		STEP_ROW_OFF    = 4'd9,
		STEP_END_OFF    = 4'd10,
		STEP_END_HOME   = 4'd11,
		STEP_END_WAIT   = 4'd12,
		STEP_LASER_OFF  = 4'd13
	} step_t;

	typedef struct packed {
		logic [SIZE_REG_W-1:0] image_width;
		logic [SIZE_REG_W-1:0] image_height;
		logic [GAIN_W-1:0]     power_gain;
		logic                  center_enable;
		logic                  dwell_enable;
		logic [DWELL_W-1:0]    dwell_time;
	} cfg_t;

	typedef struct packed {
		logic [STEP_COUNT-1:0] mask;
		logic [COORD_W-1:0]    x_coord;
		logic [COORD_W-1:0]    y_coord;
		logic [LEVEL_W-1:0]    power;
	} plan_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

FILE: rtl/core/rlcg_front.sv
// Front end: counts column and row, derives the laser power of a pixel and
// builds the set of commands that the pixel causes. Depends on rlcg_pkg.
module rlcg_front #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlcg_pkg::cfg_t                cfg,
	input  logic                          accept,
	input  logic [rlcg_pkg::LEVEL_W-1:0]  red,
	input  logic [rlcg_pkg::LEVEL_W-1:0]  green,
	input  logic [rlcg_pkg::LEVEL_W-1:0]  blue,
	output logic                          push,
	output rlcg_pkg::plan_t               plan
);

	localparam int CW = $clog2(MAX_SIDE);
	localparam int SW = CW + 1;
	localparam int EW = (SW > rlcg_pkg::COORD_W) ? SW : rlcg_pkg::COORD_W;

	logic [CW-1:0] col_q, row_q;
	logic          pend_q;

	logic [EW-1:0] w_ext, h_ext, x_diff, y_diff;
	logic [SW-1:0] w, h, w_m1, h_m1, xoff, yoff;
	logic [CW-1:0] c, r, px;
	logic [rlcg_pkg::LEVEL_W-1:0] mx, black;
	logic [23:0]   prod;
	logic [15:0]   pwr_full;
	logic          lit, row_end, img_end;

	always_comb begin
		w_ext = EW'(cfg.image_width);
		h_ext = EW'(cfg.image_height);
		// A size of zero counts as one, a size beyond the maximum as the maximum.
		if (w_ext == '0) begin
			w = SW'(1);
		end else if (w_ext > EW'(MAX_SIDE)) begin
			w = SW'(MAX_SIDE);
		end else begin
			w = SW'(w_ext);
		end
		if (h_ext == '0) begin
			h = SW'(1);
		end else if (h_ext > EW'(MAX_SIDE)) begin
			h = SW'(MAX_SIDE);
		end else begin
			h = SW'(h_ext);
		end
		w_m1 = w - SW'(1);
		h_m1 = h - SW'(1);
		// A counter left beyond a size that shrank counts as the last column or row.
		c = (SW'(col_q) < w) ? col_q : w_m1[CW-1:0];
		r = (SW'(row_q) < h) ? row_q : h_m1[CW-1:0];
		row_end = (c == w_m1[CW-1:0]);
		img_end = row_end && (r == h_m1[CW-1:0]);

		mx = (red > green) ? red : green;
		if (blue > mx) begin
			mx = blue;
		end
		black    = rlcg_pkg::PIXEL_MAX - mx;
		prod     = {16'd0, black} * {8'd0, cfg.power_gain};
		pwr_full = prod[23:8];
		lit      = (pwr_full != 16'd0);

		// Odd rows run right to left.
		px   = r[0] ? (w_m1[CW-1:0] - c) : c;
		xoff = cfg.center_enable ? (w >> 1) : '0;
		yoff = cfg.center_enable ? (h >> 1) : '0;
		x_diff = EW'(px) - EW'(xoff);
		y_diff = EW'(r) - EW'(yoff);

		plan.x_coord = x_diff[rlcg_pkg::COORD_W-1:0];
		plan.y_coord = y_diff[rlcg_pkg::COORD_W-1:0];
		plan.power   = (pwr_full > 16'(rlcg_pkg::LEVEL_MAX)) ? rlcg_pkg::LEVEL_MAX
			: pwr_full[rlcg_pkg::LEVEL_W-1:0];

		plan.mask = '0;
		if (c == '0 && r == '0) begin
			plan.mask[rlcg_pkg::STEP_START_OFF]  = 1'b1;
			plan.mask[rlcg_pkg::STEP_START_HOME] = 1'b1;
			plan.mask[rlcg_pkg::STEP_START_WAIT] = 1'b1;
			plan.mask[rlcg_pkg::STEP_LASER_ON]   = 1'b1;
		end
		plan.mask[rlcg_pkg::STEP_ROW_MOVE]  = (c == '0);
		plan.mask[rlcg_pkg::STEP_X_MOVE]    = lit;
		plan.mask[rlcg_pkg::STEP_SET_POWER] = lit;
		plan.mask[rlcg_pkg::STEP_DWELL]     = lit && cfg.dwell_enable;
		plan.mask[rlcg_pkg::STEP_RUN_OFF]   = !lit && pend_q;
		plan.mask[rlcg_pkg::STEP_ROW_OFF]   = row_end;
		if (img_end) begin
			plan.mask[rlcg_pkg::STEP_END_OFF]   = 1'b1;
			plan.mask[rlcg_pkg::STEP_END_HOME]  = 1'b1;
			plan.mask[rlcg_pkg::STEP_END_WAIT]  = 1'b1;
			plan.mask[rlcg_pkg::STEP_LASER_OFF] = 1'b1;
		end
	end

	// A dark pixel in mid-row that closes no lit run causes nothing and is dropped here.
	assign push = accept && (plan.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			// The pending power-off survives a row end and is dropped at image end.
			pend_q <= lit && !img_end;
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : (r + CW'(1));
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
		end
	end

endmodule

FILE: rtl/core/rlcg_queue.sv
// Short queue of pixel command plans between the front and the back end.
// Depends on rlcg_pkg for the plan type and the depth.
module rlcg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rlcg_pkg::plan_t       push_data,
	input  logic                  pop,
	output rlcg_pkg::plan_t       head,
	output rlcg_pkg::q_status_t   status
);

	rlcg_pkg::plan_t entries_q [rlcg_pkg::QUEUE_DEPTH];
	logic [rlcg_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rlcg_pkg::QCNT_W-1:0] count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == rlcg_pkg::QCNT_W'(rlcg_pkg::QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rlcg_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rlcg_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + rlcg_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - rlcg_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/rlcg_back.sv
// Back end: walks the command set of one pixel plan, one command per cycle
// unless the receiver stalls, into the output register. Depends on rlcg_pkg.
module rlcg_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [rlcg_pkg::DWELL_W-1:0]   dwell_time,
	input  rlcg_pkg::plan_t                head,
	input  logic                           q_empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rlcg_pkg::cmd_t                 command,
	output logic                           x_valid,
	output logic [rlcg_pkg::COORD_W-1:0]   x_coord,
	output logic                           y_valid,
	output logic [rlcg_pkg::COORD_W-1:0]   y_coord,
	output logic [rlcg_pkg::LEVEL_W-1:0]   power_level,
	output logic [rlcg_pkg::DWELL_W-1:0]   dwell_value,
	output logic                           last
);

	logic [rlcg_pkg::STEP_COUNT-1:0] mask_q, mask_clr;
	rlcg_pkg::plan_t                 plan_q;
	rlcg_pkg::step_t                 step;
	logic                            out_free, emit, load;

	rlcg_pkg::cmd_t                  n_cmd;
	logic                            n_xv, n_yv;
	logic [rlcg_pkg::COORD_W-1:0]    n_x, n_y;
	logic [rlcg_pkg::LEVEL_W-1:0]    n_pwr;
	logic [rlcg_pkg::DWELL_W-1:0]    n_dw;

	rlcg_pkg::cmd_t                  cmd_q;
	logic                            xv_q, yv_q, valid_q, last_q;
	logic [rlcg_pkg::COORD_W-1:0]    x_q, y_q;
	logic [rlcg_pkg::LEVEL_W-1:0]    pwr_q;
	logic [rlcg_pkg::DWELL_W-1:0]    dw_q;

	always_comb begin
		// The lowest pending step goes out next.
		step = rlcg_pkg::STEP_START_OFF;
		for (int i = rlcg_pkg::STEP_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				step = rlcg_pkg::step_t'(4'(i));
			end
		end
		mask_clr = mask_q & ~(rlcg_pkg::STEP_COUNT'(1) << step);
		out_free = !valid_q || out_ready;
		emit     = (mask_q != '0) && out_free;
		load     = !q_empty && ((mask_q == '0) || (emit && mask_clr == '0));

		n_cmd = rlcg_pkg::CMD_SET_POWER;
		n_xv  = 1'b0;
		n_yv  = 1'b0;
		n_x   = '0;
		n_y   = '0;
		n_pwr = '0;
		n_dw  = '0;
		case (step)
			rlcg_pkg::STEP_START_HOME, rlcg_pkg::STEP_END_HOME: begin
				n_cmd = rlcg_pkg::CMD_HOME;
			end
			rlcg_pkg::STEP_START_WAIT, rlcg_pkg::STEP_END_WAIT: begin
				n_cmd = rlcg_pkg::CMD_WAIT_MOTION;
			end
			rlcg_pkg::STEP_LASER_ON: begin
				n_cmd = rlcg_pkg::CMD_LASER_ON;
			end
			rlcg_pkg::STEP_LASER_OFF: begin
				n_cmd = rlcg_pkg::CMD_LASER_OFF;
			end
			rlcg_pkg::STEP_ROW_MOVE: begin
				n_cmd = rlcg_pkg::CMD_MOVE;
				n_yv  = 1'b1;
				n_y   = plan_q.y_coord;
			end
			rlcg_pkg::STEP_X_MOVE: begin
				n_cmd = rlcg_pkg::CMD_MOVE;
				n_xv  = 1'b1;
				n_x   = plan_q.x_coord;
			end
			rlcg_pkg::STEP_SET_POWER: begin
				n_pwr = plan_q.power;
			end
			rlcg_pkg::STEP_DWELL: begin
				n_cmd = rlcg_pkg::CMD_DWELL;
				n_dw  = dwell_time;
			end
			default: begin
				n_cmd = rlcg_pkg::CMD_SET_POWER;
			end
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= head.mask;
			end else if (emit) begin
				mask_q <= mask_clr;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= head;
		end
		if (emit) begin
			cmd_q  <= n_cmd;
			xv_q   <= n_xv;
			x_q    <= n_x;
			yv_q   <= n_yv;
			y_q    <= n_y;
			pwr_q  <= n_pwr;
			dw_q   <= n_dw;
			last_q <= (mask_clr == '0);
		end
	end

	assign out_valid   = valid_q;
	assign command     = cmd_q;
	assign x_valid     = xv_q;
	assign x_coord     = x_q;
	assign y_valid     = yv_q;
	assign y_coord     = y_q;
	assign power_level = pwr_q;
	assign dwell_value = dw_q;
	assign last        = last_q;

endmodule

FILE: rtl/core/raster_laser_command_generator_unit.sv
// Top level of the raster laser command generator: configuration registers,
// stream ports and the front end, plan queue and back end (rlcg_pkg, rlcg_*).
//
// Usage: pixels arrive on the s_axis channel in serpentine scan order, one
// transaction per pixel. Each pixel causes zero to thirteen commands on the
// m_axis channel; m_axis_tlast marks the last command of a pixel, and a dark
// pixel inside a row that ends no lit run causes none. Registers are to be
// written through cfg_we/cfg_index/cfg_data only while no pixel is in flight,
// which the block does not enforce. A pixel's plan passes the queue, the back
// end's mask register and the output register on its way to m_axis. The back
// end sends one command per cycle unless the receiver stalls; a queued plan
// has one to thirteen commands, typically two or three when lit. Pixels that
// cause no command pass the front end at one per cycle while the queue has
// room. A four-entry plan queue lets the front end accept pixels while the
// back end still works. Reset clears the column and row counters, the pending
// power-off, the queue and the output valid flag, and loads the register
// defaults. When the receiver stalls, the output register holds its command,
// the back end stops, and s_axis_tready falls once the plan queue is full.
module raster_laser_command_generator_unit #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [23:0]                       s_axis_tdata,  // red, green, blue
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// x_coord, y_coord, power_level, dwell_value, zero fill
	output logic [55:0]                       m_axis_tdata,
	output logic [4:0]                        m_axis_tuser,  // command, x_valid, y_valid
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [rlcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [rlcg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rlcg_pkg::cfg_t      cfg_q;
	rlcg_pkg::plan_t     plan, head;
	rlcg_pkg::q_status_t q_status;
	rlcg_pkg::cmd_t      command;
	logic                accept, push, pop;
	logic                x_valid, y_valid;
	logic [rlcg_pkg::COORD_W-1:0] x_coord, y_coord;
	logic [rlcg_pkg::LEVEL_W-1:0] power_level;
	logic [rlcg_pkg::DWELL_W-1:0] dwell_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= rlcg_pkg::SIZE_REG_W'(1);
			cfg_q.image_height  <= rlcg_pkg::SIZE_REG_W'(1);
			cfg_q.power_gain    <= rlcg_pkg::GAIN_W'(256);
			cfg_q.center_enable <= 1'b0;
			cfg_q.dwell_enable  <= 1'b0;
			cfg_q.dwell_time    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rlcg_pkg::CFG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[rlcg_pkg::SIZE_REG_W-1:0];
				end
				rlcg_pkg::CFG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[rlcg_pkg::SIZE_REG_W-1:0];
				end
				rlcg_pkg::CFG_POWER_GAIN: begin
					cfg_q.power_gain <= cfg_data;
				end
				rlcg_pkg::CFG_CENTER_ENABLE: begin
					cfg_q.center_enable <= cfg_data[0];
				end
				rlcg_pkg::CFG_DWELL_ENABLE: begin
					cfg_q.dwell_enable <= cfg_data[0];
				end
				rlcg_pkg::CFG_DWELL_TIME: begin
					cfg_q.dwell_time <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !q_status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	rlcg_front #(
		.MAX_SIDE (MAX_SIDE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.red    (s_axis_tdata[7:0]),
		.green  (s_axis_tdata[15:8]),
		.blue   (s_axis_tdata[23:16]),
		.push   (push),
		.plan   (plan)
	);

	rlcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (plan),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	rlcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dwell_time  (cfg_q.dwell_time),
		.head        (head),
		.q_empty     (q_status.empty),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.command     (command),
		.x_valid     (x_valid),
		.x_coord     (x_coord),
		.y_valid     (y_valid),
		.y_coord     (y_coord),
		.power_level (power_level),
		.dwell_value (dwell_value),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, dwell_value, power_level, y_coord, x_coord};
	assign m_axis_tuser = {y_valid, x_valid, command};

`ifndef ASSERT_OFF
	// The queue never holds more plans than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= rlcg_pkg::QCNT_W'(rlcg_pkg::QUEUE_DEPTH))
		else $error("plan queue count beyond its depth");

	// Laser off closes the end of an image and is always the last command of its pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && command == rlcg_pkg::CMD_LASER_OFF |-> m_axis_tlast)
		else $error("laser off not marked as last command");

	// Laser on is always followed by the row move of the same pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && command == rlcg_pkg::CMD_LASER_ON |-> !m_axis_tlast)
		else $error("laser on marked as last command");

	// A move carries exactly one coordinate.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && command == rlcg_pkg::CMD_MOVE |-> x_valid != y_valid)
		else $error("move with both or no coordinates");
`endif

endmodule
